// ----- sv/crb_pkg.sv -----
// Shared types and constants of the chunk reorder buffer.
// Holds field widths, result status codes, the slot entry layout and the
// request and response types of the shared adder unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package crb_pkg;

	localparam int IDX_W    = 32;
	localparam int SIZE_W   = 24;
	localparam int HANDLE_W = 16;
	localparam int TOTAL_W  = 40;
	localparam int STATUS_W = 3;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_STALE     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MISSING   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd5;
	localparam logic [STATUS_W-1:0] ST_FAILED    = 3'd6;

	localparam logic CMD_CHUNK = 1'b0;
	localparam logic CMD_EOS   = 1'b1;

	typedef struct packed {
		logic                valid;
		logic [SIZE_W-1:0]   size;
		logic [HANDLE_W-1:0] handle;
	} slot_entry_t;

	typedef enum logic {
		ALU_ADD_SAT = 1'b0,
		ALU_SUB     = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic               en;
		alu_op_t            op;
		logic [TOTAL_W-1:0] a;
		logic [TOTAL_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] value;
		logic               carry;
	} alu_resp_t;

endpackage
`default_nettype wire

// ----- sv/crb_slot_ram.sv -----
// Slot memory of the chunk reorder buffer: one write port, one read port
// with registered read data. Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none
module crb_slot_ram #(
	parameter int DEPTH  = 16,
	parameter int DATA_W = 41
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [DATA_W-1:0]        wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ----- sv/crb_alu.sv -----
// Shared 40-bit adder of the chunk reorder buffer with a result register.
// Does saturating adds and subtracts with borrow; uses crb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module crb_alu (
	input  wire logic               clk,
	input  wire crb_pkg::alu_req_t  req,
	output crb_pkg::alu_resp_t      resp
);
	import crb_pkg::*;

	logic [TOTAL_W:0]   wide;
	logic [TOTAL_W-1:0] value_d;
	logic [TOTAL_W-1:0] value_q;
	logic               carry_q;

	always_comb begin
		case (req.op)
			ALU_ADD_SAT: begin
				wide    = {1'b0, req.a} + {1'b0, req.b};
				value_d = wide[TOTAL_W] ? {TOTAL_W{1'b1}} : wide[TOTAL_W-1:0];
			end
			ALU_SUB: begin
				wide    = {1'b0, req.a} - {1'b0, req.b};
				value_d = wide[TOTAL_W-1:0];
			end
			default: begin
				wide    = '0;
				value_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (req.en) begin
			value_q <= value_d;
			carry_q <= wide[TOTAL_W];
		end
	end

	assign resp.value = value_q;
	assign resp.carry = carry_q;

endmodule
`default_nettype wire

// ----- sv/chunk_reorder_buffer_unit.sv -----
// Top level of the chunk reorder buffer: sequencer, state registers and
// output register. Uses crb_pkg, crb_slot_ram and crb_alu.
`timescale 1ns / 1ps
`default_nettype none
// After reset the block clears its WINDOW slot entries, one per cycle, and
// holds in_stall high while it does so; configuration writes are taken at
// any time. Chunk beats are then taken one at a time. A beat that gives a
// single status result (end of stream, any error, or an already failed
// block) ends once that result is pushed. A stored chunk is checked on the
// adder and its slot is read and written; each chunk it releases is then
// read from the slot memory, added on the one shared 40-bit adder, which
// every release uses once, and cleared. A finished result waits in the
// output register while the next beat is accepted.
module chunk_reorder_buffer_unit #(
	parameter int WINDOW = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [crb_pkg::TOTAL_W-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          cmd,
	input  wire logic [crb_pkg::IDX_W-1:0]     seq_index,
	input  wire logic [crb_pkg::SIZE_W-1:0]    chunk_size,
	input  wire logic [crb_pkg::HANDLE_W-1:0]  payload_handle,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               emit_valid,
	output logic      [crb_pkg::IDX_W-1:0]     emit_index,
	output logic      [crb_pkg::SIZE_W-1:0]    emit_size,
	output logic      [crb_pkg::HANDLE_W-1:0]  emit_handle,
	output logic      [crb_pkg::TOTAL_W-1:0]   running_total,
	output logic      [crb_pkg::STATUS_W-1:0]  status,
	output logic                               stream_done,
	output logic                               last
);
	import crb_pkg::*;

	localparam int LW  = $clog2(WINDOW);
	localparam int LW1 = LW + 1;
	localparam int PW  = $clog2(WINDOW + 1);
	localparam logic [LW1-1:0]   WIN_L  = LW1'(WINDOW);
	localparam logic [LW-1:0]    LAST_S = LW'(WINDOW - 1);
	localparam logic [IDX_W-1:0] WIN_I  = IDX_W'(WINDOW);

	localparam logic [2:0] S_CLEAR     = 3'd0;
	localparam logic [2:0] S_IDLE      = 3'd1;
	localparam logic [2:0] S_EVAL      = 3'd2;
	localparam logic [2:0] S_DUP       = 3'd3;
	localparam logic [2:0] S_DRAIN_RD  = 3'd4;
	localparam logic [2:0] S_DRAIN_CHK = 3'd5;
	localparam logic [2:0] S_DRAIN_UPD = 3'd6;

	logic [2:0]          state_q, state_d;
	logic [LW-1:0]       clr_q;
	logic [IDX_W-1:0]    ne_q;
	logic [LW-1:0]       head_q;
	logic [PW-1:0]       pend_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [TOTAL_W-1:0]  exp_q;
	logic                failed_q;
	logic                hold_q;
	logic                out_valid_q;

	logic                cmd_q;
	logic [IDX_W-1:0]    idx_q;
	logic [SIZE_W-1:0]   size_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [LW-1:0]       slot_q;
	logic [IDX_W-1:0]    hold_idx_q;
	logic [SIZE_W-1:0]   hold_size_q;
	logic [HANDLE_W-1:0] hold_handle_q;
	logic [TOTAL_W-1:0]  hold_total_q;

	logic                emit_valid_q;
	logic [IDX_W-1:0]    emit_index_q;
	logic [SIZE_W-1:0]   emit_size_q;
	logic [HANDLE_W-1:0] emit_handle_q;
	logic [TOTAL_W-1:0]  running_total_q;
	logic [STATUS_W-1:0] status_q;
	logic                stream_done_q;
	logic                last_q;

	logic                accept;
	logic                out_free;
	logic                push;
	logic                p_emit;
	logic [IDX_W-1:0]    p_idx;
	logic [SIZE_W-1:0]   p_size;
	logic [HANDLE_W-1:0] p_handle;
	logic [TOTAL_W-1:0]  p_total;
	logic [STATUS_W-1:0] p_status;
	logic                p_done;
	logic                p_last;
	logic                set_failed;
	logic                do_insert;
	logic                do_release;
	logic                clear_hold;

	logic                ram_wr_en;
	logic [LW-1:0]       ram_wr_addr;
	slot_entry_t         ram_wr_data;
	logic                ram_rd_en;
	logic [LW-1:0]       ram_rd_addr;
	logic [$bits(slot_entry_t)-1:0] ram_rd_raw;
	slot_entry_t         ram_rd;

	alu_req_t            alu_req;
	alu_resp_t           alu_resp;

	logic [LW1-1:0]      slot_sum;
	logic [LW1-1:0]      slot_wrap;
	logic [LW-1:0]       head_next;

	crb_slot_ram #(
		.DEPTH  (WINDOW),
		.DATA_W ($bits(slot_entry_t))
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_raw)
	);

	assign ram_rd = slot_entry_t'(ram_rd_raw);

	crb_alu u_alu (
		.clk  (clk),
		.req  (alu_req),
		.resp (alu_resp)
	);

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign slot_sum  = {1'b0, head_q} + {1'b0, alu_resp.value[LW-1:0]};
	assign slot_wrap = (slot_sum >= WIN_L) ? (slot_sum - WIN_L) : slot_sum;
	assign head_next = (head_q == LAST_S) ? '0 : head_q + 1'b1;

	always_comb begin
		state_d     = state_q;
		push        = 1'b0;
		p_emit      = 1'b0;
		p_idx       = '0;
		p_size      = '0;
		p_handle    = '0;
		p_total     = total_q;
		p_status    = ST_OK;
		p_done      = 1'b0;
		p_last      = 1'b1;
		set_failed  = 1'b0;
		do_insert   = 1'b0;
		do_release  = 1'b0;
		clear_hold  = 1'b0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = head_q;
		ram_wr_data = '{valid: 1'b0, size: size_q, handle: handle_q};
		ram_rd_en   = 1'b0;
		ram_rd_addr = head_q;
		alu_req     = '{en: 1'b0, op: ALU_SUB, a: '0, b: '0};

		case (state_q)
			S_CLEAR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = clr_q;
				if (clr_q == LAST_S) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					alu_req.en = 1'b1;
					alu_req.op = ALU_SUB;
					if (cmd == CMD_EOS) begin
						alu_req.a = total_q;
						alu_req.b = exp_q;
					end else begin
						alu_req.a = TOTAL_W'(seq_index);
						alu_req.b = TOTAL_W'(ne_q);
					end
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				if (failed_q) begin
					p_status = ST_FAILED;
					p_done   = cmd_q;
					push     = out_free;
				end else if (cmd_q == CMD_EOS) begin
					p_done = 1'b1;
					if (pend_q != '0) begin
						p_status = ST_MISSING;
					end else if (exp_q != '0 && alu_resp.value != '0) begin
						p_status = ST_MISMATCH;
					end
					push       = out_free;
					set_failed = out_free && (p_status != ST_OK);
				end else if (alu_resp.carry) begin
					p_status   = ST_STALE;
					push       = out_free;
					set_failed = out_free;
				end else if (alu_resp.value[IDX_W-1:0] >= WIN_I) begin
					p_status   = ST_OVERFLOW;
					push       = out_free;
					set_failed = out_free;
				end else begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = slot_wrap[LW-1:0];
					state_d     = S_DUP;
				end
				if (push) begin
					state_d = S_IDLE;
				end
			end
			S_DUP: begin
				if (ram_rd.valid) begin
					p_status   = ST_DUPLICATE;
					push       = out_free;
					set_failed = out_free;
					if (out_free) begin
						state_d = S_IDLE;
					end
				end else begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = slot_q;
					ram_wr_data = '{valid: 1'b1, size: size_q, handle: handle_q};
					do_insert   = 1'b1;
					state_d     = S_DRAIN_RD;
				end
			end
			S_DRAIN_RD: begin
				ram_rd_en   = 1'b1;
				ram_rd_addr = head_q;
				state_d     = S_DRAIN_CHK;
			end
			S_DRAIN_CHK: begin
				if (ram_rd.valid) begin
					alu_req.en = 1'b1;
					alu_req.op = ALU_ADD_SAT;
					alu_req.a  = total_q;
					alu_req.b  = TOTAL_W'(ram_rd.size);
					state_d    = S_DRAIN_UPD;
				end else begin
					if (hold_q) begin
						p_emit   = 1'b1;
						p_idx    = hold_idx_q;
						p_size   = hold_size_q;
						p_handle = hold_handle_q;
						p_total  = hold_total_q;
					end
					push       = out_free;
					clear_hold = out_free;
					if (out_free) begin
						state_d = S_IDLE;
					end
				end
			end
			S_DRAIN_UPD: begin
				if (!hold_q || out_free) begin
					if (hold_q) begin
						push     = 1'b1;
						p_emit   = 1'b1;
						p_idx    = hold_idx_q;
						p_size   = hold_size_q;
						p_handle = hold_handle_q;
						p_total  = hold_total_q;
						p_last   = 1'b0;
					end
					ram_wr_en   = 1'b1;
					ram_wr_addr = head_q;
					ram_wr_data = '{valid: 1'b0, size: ram_rd.size, handle: ram_rd.handle};
					do_release  = 1'b1;
					state_d     = S_DRAIN_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			ne_q        <= '0;
			head_q      <= '0;
			pend_q      <= '0;
			total_q     <= '0;
			exp_q       <= '0;
			failed_q    <= 1'b0;
			hold_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				exp_q <= cfg_data;
			end
			if (set_failed) begin
				failed_q <= 1'b1;
			end
			if (do_insert) begin
				pend_q <= pend_q + 1'b1;
			end
			if (do_release) begin
				pend_q  <= pend_q - 1'b1;
				total_q <= alu_resp.value;
				ne_q    <= ne_q + 1'b1;
				head_q  <= head_next;
				hold_q  <= 1'b1;
			end else if (clear_hold) begin
				hold_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			idx_q    <= seq_index;
			size_q   <= chunk_size;
			handle_q <= payload_handle;
		end
		if (state_q == S_EVAL) begin
			slot_q <= slot_wrap[LW-1:0];
		end
		if (do_release) begin
			hold_idx_q    <= ne_q;
			hold_size_q   <= ram_rd.size;
			hold_handle_q <= ram_rd.handle;
			hold_total_q  <= alu_resp.value;
		end
		if (push) begin
			emit_valid_q    <= p_emit;
			emit_index_q    <= p_idx;
			emit_size_q     <= p_size;
			emit_handle_q   <= p_handle;
			running_total_q <= p_total;
			status_q        <= p_status;
			stream_done_q   <= p_done;
			last_q          <= p_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign emit_valid    = emit_valid_q;
	assign emit_index    = emit_index_q;
	assign emit_size     = emit_size_q;
	assign emit_handle   = emit_handle_q;
	assign running_total = running_total_q;
	assign status        = status_q;
	assign stream_done   = stream_done_q;
	assign last          = last_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PW'(WINDOW))
		else $error("pending count exceeds the window");

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while a beat waits");

	assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |=> failed_q)
		else $error("failed flag cleared");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && emit_valid) |-> (status == ST_OK && !stream_done))
		else $error("released chunk carries an error or end of stream");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUP) |-> (idx_q - ne_q < WIN_I))
		else $error("insert outside the window");
`endif

endmodule
`default_nettype wire
